/* sv/swt_pkg.sv */
// ---------------------------------------------------------------------------
// swt_pkg - shared types and codes for the sorted word table
// Request and result payload structs, operation and status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package swt_pkg;

    localparam int OP_W   = 2;
    localparam int WORD_W = 64;
    localparam int STAT_W = 2;
    localparam int POS_W  = 8;
    localparam int CNT_W  = 9;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SORT   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_SORTED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] word;
    } t_request;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  entry_count;
    } t_result;

endpackage

`default_nettype wire

/* sv/swt_mem.sv */
// ---------------------------------------------------------------------------
// swt_mem - word store
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module swt_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/swt_engine.sv */
// ---------------------------------------------------------------------------
// swt_engine - table sequencer
// Append, clear, binary search and heapsort over one memory with one write and one read port,
// with a single shared comparator.
// ---------------------------------------------------------------------------
`default_nettype none

module swt_engine #(
    parameter int TABLE_DEPTH = 256,
    parameter int WW          = 64,
    parameter int AW          = 8,
    parameter int CW          = 9
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [swt_pkg::OP_W-1:0]   i_op,
    input  wire logic [WW-1:0]              i_word,
    output logic                            o_busy,
    output logic                            o_done,
    output swt_pkg::t_result                o_result,
    output logic                            o_mem_we,
    output logic      [AW-1:0]              o_mem_waddr,
    output logic      [WW-1:0]              o_mem_wdata,
    output logic      [AW-1:0]              o_mem_raddr,
    input  wire logic [WW-1:0]              i_mem_rdata
);

    localparam int KW = AW + 2;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_LD       = 4'd3;
    localparam logic [3:0] S_LDW      = 4'd4;
    localparam logic [3:0] S_CHK      = 4'd5;
    localparam logic [3:0] S_K1       = 4'd6;
    localparam logic [3:0] S_K2       = 4'd7;
    localparam logic [3:0] S_K3       = 4'd8;
    localparam logic [3:0] S_X0       = 4'd9;
    localparam logic [3:0] S_X1       = 4'd10;
    localparam logic [3:0] S_X2       = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic          r_sorted, n_sorted;
    logic          r_build, n_build;
    logic [WW-1:0] r_key, n_key;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_mid, n_mid;
    logic [AW-1:0] r_at, n_at;
    logic [AW-1:0] r_kid, n_kid;
    logic [AW-1:0] r_i, n_i;
    logic [CW-1:0] r_heap, n_heap;
    logic [WW-1:0] r_vat, n_vat;
    logic [WW-1:0] r_vkid, n_vkid;
    logic          r_has2, n_has2;

    logic [WW-1:0] cmp_a, cmp_b;
    logic          cmp_gt, cmp_eq;
    logic [KW-1:0] kid_w, kid2_w, heap_w;
    logic          has_kid, has_two;
    logic [CW-1:0] span, mid_w;
    logic          sink_end;
    logic          done;
    logic [swt_pkg::STAT_W-1:0] status;
    logic [AW-1:0] pos_idx;
    logic [AW+swt_pkg::POS_W-1:0] pos_ext;
    logic [CW+swt_pkg::CNT_W-1:0] cnt_ext;

    // shared comparator
    always_comb begin
        unique case (r_state)
            S_K2:    begin cmp_a = i_mem_rdata; cmp_b = r_vkid; end
            S_K3:    begin cmp_a = r_vat;       cmp_b = r_vkid; end
            default: begin cmp_a = i_mem_rdata; cmp_b = r_key;  end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;
    assign cmp_eq = cmp_a == cmp_b;

    assign kid_w   = KW'({r_at, 1'b1});
    assign kid2_w  = kid_w + KW'(1);
    assign heap_w  = KW'(r_heap);
    assign has_kid = kid_w < heap_w;
    assign has_two = kid2_w < heap_w;

    assign span  = r_hi - r_lo - CW'(1);
    assign mid_w = r_lo + (span >> 1);

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_sorted = r_sorted;
        n_build  = r_build;
        n_key    = r_key;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_at     = r_at;
        n_kid    = r_kid;
        n_i      = r_i;
        n_heap   = r_heap;
        n_vat    = r_vat;
        n_vkid   = r_vkid;
        n_has2   = r_has2;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_at;
        o_mem_wdata = r_vat;
        o_mem_raddr = r_at;
        sink_end = 1'b0;
        done     = 1'b0;
        status   = swt_pkg::ST_OK;
        pos_idx  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        swt_pkg::OP_APPEND: begin
                            done = 1'b1;
                            if (r_total >= CW'(TABLE_DEPTH)) begin
                                status = swt_pkg::ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_total[AW-1:0];
                                o_mem_wdata = i_word;
                                n_total     = r_total + CW'(1);
                                n_sorted    = 1'b0;
                            end
                        end
                        swt_pkg::OP_SORT: begin
                            if (r_total < CW'(2)) begin
                                done     = 1'b1;
                                n_sorted = 1'b1;
                            end else begin
                                n_build = 1'b1;
                                n_i     = AW'((r_total - CW'(1)) >> 1);
                                n_at    = AW'((r_total - CW'(1)) >> 1);
                                n_heap  = r_total;
                                n_state = S_LD;
                            end
                        end
                        swt_pkg::OP_LOOKUP: begin
                            if (!r_sorted) begin
                                done   = 1'b1;
                                status = swt_pkg::ST_NOT_SORTED;
                            end else begin
                                n_key   = i_word;
                                n_lo    = '0;
                                n_hi    = r_total;
                                n_state = S_SRCH_RD;
                            end
                        end
                        swt_pkg::OP_CLEAR: begin
                            done     = 1'b1;
                            n_total  = '0;
                            n_sorted = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    o_mem_raddr = mid_w[AW-1:0];
                    n_mid       = mid_w[AW-1:0];
                    n_state     = S_SRCH_CMP;
                end else begin
                    done    = 1'b1;
                    status  = swt_pkg::ST_NOT_FOUND;
                    n_state = S_IDLE;
                end
            end
            S_SRCH_CMP: begin
                priority if (cmp_eq) begin
                    done    = 1'b1;
                    pos_idx = r_mid;
                    n_state = S_IDLE;
                end else if (cmp_gt) begin
                    n_hi    = CW'(r_mid);
                    n_state = S_SRCH_RD;
                end else begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_LD: begin
                o_mem_raddr = r_at;
                n_state     = S_LDW;
            end
            S_LDW: begin
                n_vat   = i_mem_rdata;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (has_kid) begin
                    o_mem_raddr = kid_w[AW-1:0];
                    n_kid       = kid_w[AW-1:0];
                    n_has2      = has_two;
                    n_state     = S_K1;
                end else begin
                    o_mem_we = 1'b1;
                    sink_end = 1'b1;
                end
            end
            S_K1: begin
                n_vkid      = i_mem_rdata;
                o_mem_raddr = kid2_w[AW-1:0];
                n_state     = S_K2;
            end
            S_K2: begin
                if (r_has2 && cmp_gt) begin
                    n_vkid = i_mem_rdata;
                    n_kid  = r_kid + AW'(1);
                end
                n_state = S_K3;
            end
            S_K3: begin
                o_mem_we = 1'b1;
                if (cmp_gt) begin
                    sink_end = 1'b1;
                end else begin
                    o_mem_wdata = r_vkid;
                    n_at        = r_kid;
                    n_state     = S_CHK;
                end
            end
            S_X0: begin
                o_mem_raddr = '0;
                n_state     = S_X1;
            end
            S_X1: begin
                n_vkid      = i_mem_rdata;
                o_mem_raddr = r_i;
                n_state     = S_X2;
            end
            S_X2: begin
                n_vat       = i_mem_rdata;
                o_mem_we    = 1'b1;
                o_mem_waddr = r_i;
                o_mem_wdata = r_vkid;
                n_at        = '0;
                n_heap      = CW'(r_i);
                n_state     = S_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // sift-down finished: next heapify node, next extraction, or done
        if (sink_end) begin
            priority if (r_build && r_i == '0) begin
                n_build = 1'b0;
                n_i     = AW'(r_total - CW'(1));
                n_state = S_X0;
            end else if (r_build) begin
                n_i     = r_i - AW'(1);
                n_at    = r_i - AW'(1);
                n_state = S_LD;
            end else if (r_i == AW'(1)) begin
                done     = 1'b1;
                n_sorted = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_i     = r_i - AW'(1);
                n_state = S_X0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_sorted <= 1'b0;
            r_build  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_sorted <= n_sorted;
            r_build  <= n_build;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_at   <= n_at;
        r_kid  <= n_kid;
        r_i    <= n_i;
        r_heap <= n_heap;
        r_vat  <= n_vat;
        r_vkid <= n_vkid;
        r_has2 <= n_has2;
    end

    assign pos_ext = (AW + swt_pkg::POS_W)'(pos_idx);
    assign cnt_ext = (CW + swt_pkg::CNT_W)'(n_total);

    assign o_busy               = r_state != S_IDLE;
    assign o_done               = done;
    assign o_result.status      = status;
    assign o_result.position    = pos_ext[swt_pkg::POS_W-1:0];
    assign o_result.entry_count = cnt_ext[swt_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

/* sv/sorted_word_table_top.sv */
// Append, clear, lookup before a sort, sort of under two words: result strobe in the cycle
// after the request; busy stays low, so these requests can follow every cycle.
// Lookup: each binary-search probe runs S_SRCH_RD then S_SRCH_CMP; an absent word ends in S_SRCH_RD.
// Sort of N words: each sift-down level steps through states S_CHK, S_K1, S_K2 and S_K3,
// paced by the one read port and the shared comparator. busy is high meanwhile.
// Results strobe for one cycle, no receiver stall. Reset empties the table, clears sorted.
// ---------------------------------------------------------------------------
// sorted_word_table_top - sorted word table
// Word table with append, in-place heapsort, binary-search lookup and clear.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_word_table_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int WORD_CHARS  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire swt_pkg::t_request i_request,
    output logic                   busy,
    output logic                   o_valid,
    output swt_pkg::t_result       o_result
);

    localparam int WW = 8 * WORD_CHARS;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [swt_pkg::CNT_W-1:0] FULL_CNT =
        swt_pkg::CNT_W'(TABLE_DEPTH % 512);

    logic             eng_busy;
    logic             eng_done;
    swt_pkg::t_result eng_result;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [WW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [WW-1:0]    mem_rdata;
    logic [WW-1:0]    word_kept;

    logic             r_valid;
    swt_pkg::t_result r_result;

    // only the leading characters are kept
    assign word_kept = i_request.word[swt_pkg::WORD_W-1 -: WW];

    swt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WW          (WW),
        .AW          (AW),
        .CW          (CW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_request.operation),
        .i_word      (word_kept),
        .o_busy      (eng_busy),
        .o_done      (eng_done),
        .o_result    (eng_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    swt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (WW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= eng_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_result <= eng_result;
        end
    end

    assign busy     = eng_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_pos_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != swt_pkg::ST_OK) |-> o_result.position == '0)
        else $error("nonzero position on a failed request");

    a_valid_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start || busy))
        else $error("result strobe without a request in flight");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == swt_pkg::ST_FULL) |-> o_result.entry_count == FULL_CNT)
        else $error("table full reported below capacity");
`endif

endmodule

`default_nettype wire
